FILE: rtl/crcpf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet framer.
package crcpf_pkg;

	// Framing constants.
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  SHORT_START = 8'd2;
	localparam logic [7:0]  LONG_START  = 8'd3;
	localparam logic [7:0]  END_BYTE    = 8'd3;
	localparam logic [7:0]  LEN_LIMIT_HI = 8'd1; // lengths of 256 and more take a long header
	localparam int          QUEUE_DEPTH = 4;

	// One input request: a payload byte with its packet information.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_length;
		logic        last_byte;
	} in_t;

	// One output request: a byte of the framed stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_t;

	// Header that precedes a payload byte.
	typedef enum logic [1:0] {
		HDR_NONE  = 2'd0,
		HDR_SHORT = 2'd1,
		HDR_LONG  = 2'd2
	} hdr_kind_t;

	// Classified work handed from the front end to the byte sequencer.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_length;
		hdr_kind_t   hdr_kind;
		logic        last_byte;
		logic [15:0] crc;
	} cmd_t;

	// Folds one byte into the CRC, most significant bit first.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/crcpf_front.sv
// Front end: accepts payload bytes, tracks packet state, chooses the header and runs the CRC.
module crcpf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  crcpf_pkg::in_t   in_data,
	output logic             push,
	output crcpf_pkg::cmd_t  push_cmd,
	input  logic             queue_full
);
	import crcpf_pkg::*;

	logic        in_packet_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// A new packet restarts the CRC from zero.
	assign crc_base = in_packet_q ? crc_q : 16'h0000;
	assign crc_next = crc_update(crc_base, in_data.data_byte);

	// Classify the request and build the command for the sequencer.
	always_comb begin
		push_cmd.data_byte      = in_data.data_byte;
		push_cmd.payload_length = in_data.payload_length;
		push_cmd.last_byte      = in_data.last_byte;
		push_cmd.crc            = crc_next;
		if (in_packet_q) begin
			push_cmd.hdr_kind = HDR_NONE;
		end else if (in_data.payload_length[15:8] < LEN_LIMIT_HI) begin
			push_cmd.hdr_kind = HDR_SHORT;
		end else begin
			push_cmd.hdr_kind = HDR_LONG;
		end
	end

	// Packet state; the last byte closes the packet and clears the CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			crc_q       <= 16'h0000;
		end else if (push) begin
			in_packet_q <= !in_data.last_byte;
			crc_q       <= in_data.last_byte ? 16'h0000 : crc_next;
		end
	end

endmodule

FILE: rtl/crcpf_queue.sv
// Short command queue between the front end and the byte sequencer.
module crcpf_queue #(
	parameter int DEPTH = crcpf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  crcpf_pkg::cmd_t  push_cmd,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output crcpf_pkg::cmd_t  head_cmd
);
	import crcpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Overflow and underflow would mean the handshakes above are wrong.
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("command queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("command queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) (push && !pop) |=> !empty)
		else $error("command queue lost an entry");

endmodule

FILE: rtl/crcpf_back.sv
// Back end: steps through header, payload and trailer bytes of each command into the output register.
module crcpf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  crcpf_pkg::cmd_t  cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output crcpf_pkg::out_t  out_data
);
	import crcpf_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_t       out_data_q;
	logic [2:0] hdr_n;
	logic [2:0] total_n;
	logic [2:0] tail_idx;
	logic       advance;
	logic       step_last;
	out_t       next_out;

	// Number of header bytes and of bytes in this command.
	always_comb begin
		case (cmd.hdr_kind)
			HDR_SHORT: hdr_n = 3'd2;
			HDR_LONG:  hdr_n = 3'd3;
			default:   hdr_n = 3'd0;
		endcase
	end
	assign total_n   = hdr_n + (cmd.last_byte ? 3'd4 : 3'd1);
	assign tail_idx  = idx_q - hdr_n - 3'd1;
	assign step_last = (idx_q == total_n - 3'd1);

	// Pick the byte for the current step.
	always_comb begin
		next_out.run_last  = step_last;
		next_out.frame_end = 1'b0;
		if (idx_q < hdr_n) begin
			if (idx_q == 3'd0) begin
				next_out.out_byte = (cmd.hdr_kind == HDR_SHORT) ? SHORT_START : LONG_START;
			end else if (idx_q == 3'd1 && cmd.hdr_kind == HDR_LONG) begin
				next_out.out_byte = cmd.payload_length[15:8];
			end else begin
				next_out.out_byte = cmd.payload_length[7:0];
			end
		end else if (idx_q == hdr_n) begin
			next_out.out_byte = cmd.data_byte;
		end else begin
			case (tail_idx)
				3'd0:    next_out.out_byte = cmd.crc[15:8];
				3'd1:    next_out.out_byte = cmd.crc[7:0];
				default: begin
					next_out.out_byte  = END_BYTE;
					next_out.frame_end = 1'b1;
				end
			endcase
		end
	end

	// The output register takes a new byte whenever it is empty or being drained.
	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && cmd_valid && step_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				idx_q <= step_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance && cmd_valid) begin
			out_data_q <= next_out;
		end
	end

	// The closing byte ends the command and carries the end byte value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.frame_end) |-> (out_data_q.run_last &&
		out_data_q.out_byte == END_BYTE))
		else $error("frame end without run end or with wrong byte");
	// A command never has more than seven steps.
	assert property (@(posedge clk) disable iff (!arst_n) idx_q <= 3'd6)
		else $error("step counter overran");
	// A finished command leaves the counter at its first step.
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> idx_q == 3'd0)
		else $error("step counter not cleared after pop");

endmodule

FILE: rtl/crc16_packet_framer.sv
// Top level of the CRC-16 packet framer: front end, command queue and byte sequencer.
//
// Usage: payload bytes arrive on the in channel (in_valid/in_ready/in_data), each request
// carrying the byte, the packet length (sampled on the first byte of a packet) and a
// last-byte flag. Framed bytes leave on the out channel (out_valid/out_ready/out_data),
// one request per byte; run_last marks the final byte produced by an input request and
// frame_end marks the closing end byte.
// An accepted request goes into the command queue, and its output bytes are registered.
// Throughput: the sequencer emits one byte per cycle while a command is queued and the
// receiver takes bytes. A request yields 1 byte for a middle payload byte, 3 or 4 for the
// first byte of a packet (short or long header), 4 for the last and up to 7 for a
// single-byte packet. The queue of QUEUE_DEPTH commands lets the input keep being accepted
// while the sequencer is busy with headers and trailers; in_ready drops only when it is full.
// Reset clears the packet state, the CRC, the queue and the output register.
// When the receiver holds out_ready low the output byte stays put, the sequencer stops,
// and once the queue fills in_ready falls.
module crc16_packet_framer #(
	parameter int QUEUE_DEPTH = crcpf_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  crcpf_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output crcpf_pkg::out_t out_data
);
	import crcpf_pkg::*;

	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;
	cmd_t push_cmd;
	cmd_t head_cmd;

	// Accept and classify.
	crcpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// Decouple the two halves.
	crcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head_cmd (head_cmd)
	);

	// Emit the framed bytes.
	crcpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!queue_empty),
		.cmd       (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: verif/tb_crc16_packet_framer.sv
// Self-checking testbench for the CRC-16 packet framer, with a reference predictor and random stalls.
`timescale 1ns / 100ps

module tb_crc16_packet_framer;

	import crcpf_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 4;
	localparam int MAX_IDLE     = 10;
	localparam int LONG_HOLD    = 100;
	localparam int DRAIN_CYCLES = 12;
	localparam int STALL_LIMIT  = 1000;
	localparam int TARGET_REQS  = 360;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// Requests waiting to be offered, and framed bytes waiting to be seen.
	in_t  payload_requests[$];
	out_t pending_frame_bytes[$];

	// Predictor state: running CRC and whether a header has gone out.
	logic [15:0] crc_acc  = '0;
	logic        pkt_open = 1'b0;

	int fail_count    = 0;
	int bytes_checked = 0;
	int payload_seen  = 0;
	int short_hdrs    = 0;
	int long_hdrs     = 0;
	int packets_done  = 0;
	int idle_cycles   = 0;

	// Sender and receiver pacing.
	int   send_gap    = 0;
	logic send_calm   = 1'b0;
	int   recv_wait   = 0;
	int   recv_draw   = 0;
	int   hold_left   = 0;
	logic recv_calm   = 1'b0;

	crc16_packet_framer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// CRC-16 with polynomial 0x1021, one data bit at a time, most significant first.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic int draw_wait(input logic calm);
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Works out the framed bytes that one accepted request produces and queues them.
	task automatic frame_request(input in_t req);
		logic [7:0] seq[$];
		out_t       item;
		if (!pkt_open) begin
			crc_acc = '0;
			if (req.payload_length[15:8] < LEN_LIMIT_HI) begin
				seq.push_back(SHORT_START);
				seq.push_back(req.payload_length[7:0]);
				short_hdrs++;
			end else begin
				seq.push_back(LONG_START);
				seq.push_back(req.payload_length[15:8]);
				seq.push_back(req.payload_length[7:0]);
				long_hdrs++;
			end
			pkt_open = 1'b1;
		end
		seq.push_back(req.data_byte);
		crc_acc = crc16_fold(crc_acc, req.data_byte);
		payload_seen++;
		if (req.last_byte) begin
			seq.push_back(crc_acc[15:8]);
			seq.push_back(crc_acc[7:0]);
			seq.push_back(END_BYTE);
			crc_acc  = '0;
			pkt_open = 1'b0;
			packets_done++;
		end
		for (int i = 0; i < seq.size(); i++) begin
			item.out_byte  = seq[i];
			item.run_last  = (i == seq.size() - 1);
			item.frame_end = req.last_byte && (i == seq.size() - 1);
			pending_frame_bytes.push_back(item);
		end
	endtask

	// Compares one received byte with the oldest expectation.
	task automatic check_frame_byte(input out_t got);
		out_t want;
		if (pending_frame_bytes.size() == 0) begin
			$error("unexpected output byte %02h with nothing expected", got.out_byte);
			fail_count++;
		end else begin
			want = pending_frame_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				fail_count++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				fail_count++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
				fail_count++;
			end
		end
		bytes_checked++;
	endtask

	task automatic add_request(input logic [7:0] d, input logic [15:0] len, input logic last);
		in_t req;
		req.data_byte      = d;
		req.payload_length = len;
		req.last_byte      = last;
		payload_requests.push_back(req);
	endtask

	// Queues a packet of n bytes; later bytes carry random lengths, which must be ignored.
	task automatic add_packet(input int n, input logic [15:0] len);
		for (int i = 0; i < n; i++) begin
			add_request(8'($urandom_range(0, 255)),
				(i == 0) ? len : 16'($urandom_range(0, 65535)), i == n - 1);
		end
	endtask

	// Driver: offers queued requests with random gaps and predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				frame_request(in_data);
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (payload_requests.size() != 0) begin
					in_data  <= payload_requests.pop_front();
					in_valid <= 1'b1;
					send_gap <= draw_wait(send_calm);
					if ($urandom_range(0, 19) == 0) begin
						send_calm <= !send_calm;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes output bytes with random stalls and two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			hold_left <= 0;
		end else if (out_valid && out_ready) begin
			check_frame_byte(out_data);
			if (bytes_checked == 100 || bytes_checked == 350) begin
				out_ready <= 1'b0;
				hold_left <= LONG_HOLD;
			end else begin
				// One draw per byte sets how many cycles ready stays low.
				recv_draw = draw_wait(recv_calm);
				if (recv_draw != 0) begin
					out_ready <= 1'b0;
					recv_wait <= recv_draw - 1;
				end
				if ($urandom_range(0, 19) == 0) begin
					recv_calm <= !recv_calm;
				end
			end
		end else if (!out_ready) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int sel;
		int n;
		logic [15:0] len;

		// Directed part: zero and extreme lengths, single-byte packets, header boundary.
		add_request(8'h00, 16'd0, 1'b1);
		add_request(8'hFF, 16'd255, 1'b1);
		add_request(8'hA5, 16'd256, 1'b0);
		add_request(8'h5A, 16'hFFFF, 1'b0);
		add_request(8'hFF, 16'd0, 1'b1);
		add_request(8'h80, 16'hFFFF, 1'b1);
		// Length that disagrees with the number of bytes sent.
		add_request(8'h01, 16'd1, 1'b0);
		add_request(8'h02, 16'd1, 1'b0);
		add_request(8'h03, 16'd1, 1'b0);
		add_request(8'h04, 16'd1, 1'b1);
		// The usual check string; its CRC is 0x31C3.
		for (int i = 0; i < 9; i++) begin
			add_request(8'(8'h31 + i), 16'd9, i == 8);
		end
		add_request(8'h00, 16'h8000, 1'b0);
		add_request(8'h7F, 16'h00FF, 1'b1);

		// Random part: mostly whole packets, some stray single requests.
		while (payload_requests.size() < TARGET_REQS) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				n = (sel < 5) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				case ($urandom_range(0, 3))
					0, 1: len = 16'(n);
					2: len = 16'($urandom_range(0, 65535));
					default: len = 16'($urandom_range(0, 255));
				endcase
				add_packet(n, len);
			end else begin
				add_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
		end while (payload_requests.size() != 0 || in_valid || pending_frame_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d payload bytes in %0d closed packets (%0d short, %0d long headers).",
			payload_seen, packets_done, short_hdrs, long_hdrs);
		$display("Checked %0d framed bytes, %0d mismatches.", bytes_checked, fail_count);
		if (fail_count == 0 && pending_frame_bytes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
